// ===== design/gmt_pkg.sv =====
package gmt_pkg;

  localparam int GROUPS_DEF = 16;
  localparam int SLOTS_DEF  = 16;

  localparam int OP_W   = 2;
  localparam int GRP_W  = 8;
  localparam int MEM_W  = 22;
  localparam int STAT_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_DELETE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_UNUSED = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_ILLEGAL = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef struct packed {
    logic clr;
    logic load;
    logic scan;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic need_scan;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

// ===== design/gmt_intf.sv =====
interface gmt_req_if import gmt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [GRP_W-1:0]  group_id;
  logic [MEM_W-1:0]  member_id;

  modport source (output valid, operation, group_id, member_id, input ready);
  modport sink   (input valid, operation, group_id, member_id, output ready);
endinterface

interface gmt_rsp_if import gmt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;

  modport source (output valid, status, input ready);
  modport sink   (input valid, status, output ready);
endinterface

// ===== design/gmt_ram.sv =====
module gmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== design/gmt_ctrl.sv =====
module gmt_ctrl import gmt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  typedef enum logic [1:0] {
    S_CLR,
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.need_scan ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  assign req_ready_o = (state_q == S_IDLE);
endmodule

// ===== design/gmt_dp.sv =====
module gmt_dp import gmt_pkg::*; #(
  parameter int GROUPS = GROUPS_DEF,
  parameter int SLOTS  = SLOTS_DEF,
  localparam int DEPTH = GROUPS * SLOTS,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [OP_W-1:0]   operation_i,
  input  logic [GRP_W-1:0]  group_id_i,
  input  logic [MEM_W-1:0]  member_id_i,
  output logic              ram_we_o,
  output logic [AW-1:0]     ram_waddr_o,
  output logic [MEM_W:0]    ram_wdata_o,
  output logic [AW-1:0]     ram_raddr_o,
  input  logic [MEM_W:0]    ram_rdata_i,
  input  logic              rsp_ready_i,
  output logic              rsp_valid_o,
  output logic [STAT_W-1:0] status_o
);
  localparam int SW    = $clog2(SLOTS + 1);

  logic [OP_W-1:0]   op_q;
  logic [MEM_W-1:0]  id_q;
  logic              legal_q;
  logic [AW-1:0]     addr_q;
  logic [AW-1:0]     ev_addr_q;
  logic [SW-1:0]     slot_q;
  logic              pend_q;
  logic              seen_q, seen_d;
  logic              found_q, found_d;
  logic              rsp_valid_q;
  logic [STAT_W-1:0] status_q;
  status_e           status_d;

  logic              legal;
  logic [AW-1:0]     base;
  logic              issue;
  logic              rd_valid;
  logic [MEM_W-1:0]  rd_id;
  logic              add_wr;

  assign legal    = ({1'b0, group_id_i} < (GRP_W + 1)'(GROUPS));
  assign base     = AW'(32'(group_id_i) * SLOTS);
  assign issue    = cmd_i.scan && (slot_q != SW'(SLOTS));
  assign rd_valid = ram_rdata_i[MEM_W];
  assign rd_id    = ram_rdata_i[MEM_W-1:0];

  always_comb begin
    ram_we_o    = 1'b0;
    ram_waddr_o = ev_addr_q;
    ram_wdata_o = '0;
    add_wr      = 1'b0;
    if (cmd_i.clr) begin
      ram_we_o    = 1'b1;
      ram_waddr_o = addr_q;
    end else if (cmd_i.scan && pend_q) begin
      unique case (op_q)
        OP_ADD: begin
          if (!found_q && !rd_valid) begin
            add_wr      = 1'b1;
            ram_we_o    = 1'b1;
            ram_wdata_o = {1'b1, id_q};
          end
        end
        OP_DELETE: begin
          if (rd_valid && (rd_id == id_q)) begin
            ram_we_o = 1'b1;
          end
        end
        OP_CLEAR: ram_we_o = 1'b1;
        default: ram_we_o = 1'b0;
      endcase
    end
  end

  assign ram_raddr_o = addr_q;
  assign seen_d      = seen_q | (cmd_i.scan & pend_q & rd_valid);
  assign found_d     = found_q | add_wr;

  always_comb begin
    if (!legal_q) begin
      status_d = ST_ILLEGAL;
    end else begin
      unique case (op_q)
        OP_ADD:    status_d = found_q ? ST_OK : ST_FULL;
        OP_DELETE,
        OP_CLEAR:  status_d = seen_q ? ST_OK : ST_EMPTY;
        default:   status_d = ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= '0;
      slot_q      <= '0;
      pend_q      <= 1'b0;
      seen_q      <= 1'b0;
      found_q     <= 1'b0;
      legal_q     <= 1'b0;
      op_q        <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        op_q    <= operation_i;
        legal_q <= legal;
        addr_q  <= base;
        slot_q  <= '0;
        pend_q  <= 1'b0;
        seen_q  <= 1'b0;
        found_q <= 1'b0;
      end else if (cmd_i.clr) begin
        addr_q <= addr_q + AW'(1);
      end else if (cmd_i.scan) begin
        if (issue) begin
          addr_q <= addr_q + AW'(1);
          slot_q <= slot_q + SW'(1);
        end
        pend_q  <= issue;
        seen_q  <= seen_d;
        found_q <= found_d;
      end
      if (cmd_i.finish) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      id_q <= member_id_i;
    end
    if (cmd_i.scan) begin
      ev_addr_q <= addr_q;
    end
    if (cmd_i.finish) begin
      status_q <= status_d;
    end
  end

  assign sts_o.clr_last  = (addr_q == AW'(DEPTH - 1));
  assign sts_o.need_scan = legal && (operation_i != OP_UNUSED);
  assign sts_o.scan_done = found_q || (!pend_q && (slot_q == SW'(SLOTS)));
  assign sts_o.out_free  = !rsp_valid_q || rsp_ready_i;

  assign rsp_valid_o = rsp_valid_q;
  assign status_o    = status_q;
endmodule

// ===== design/group_membership_table.sv =====
// Channel  Dir  Payload                                 Transaction
// req_i    in   operation[1:0] group_id[7:0] member_id  one request
// rsp_o    out  status[1:0]                             one result per request
//
// Add scans the group's slots up to the first free one and stops there.
// Delete and clear read every slot of the group.
// Illegal group or unused operation: no slot is scanned or written.
// The slot RAM has one write port and is read one slot a cycle during a scan.
// After reset a clearing pass writes all GROUPS * SLOTS entries before req_i.ready.
// A result held by rsp_o stall lets one more request in; it then waits.
module group_membership_table import gmt_pkg::*; #(
  parameter int GROUPS = GROUPS_DEF,
  parameter int SLOTS  = SLOTS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gmt_req_if.sink   req_i,
  gmt_rsp_if.source rsp_o
);
  localparam int DEPTH = GROUPS * SLOTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t            cmd;
  sts_t            sts;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [MEM_W:0]  ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [MEM_W:0]  ram_rdata;

  gmt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gmt_dp #(
    .GROUPS (GROUPS),
    .SLOTS  (SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .operation_i (req_i.operation),
    .group_id_i  (req_i.group_id),
    .member_id_i (req_i.member_id),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_o.valid),
    .status_o    (rsp_o.status)
  );

  gmt_ram #(
    .WIDTH (MEM_W + 1),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );
endmodule
